// ===== design/xor_parity_frame_parser_macros.svh =====
// Assertion macros for the frame parser; only the queue module uses them.
`ifndef XOR_PARITY_FRAME_PARSER_MACROS_SVH
`define XOR_PARITY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define XPFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xpfp: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define XPFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xpfp: next-cycle check failed");

`endif

// ===== design/xpfp_pkg.sv =====
// Types and constants shared by the frame parser modules.
`default_nettype none

package xpfp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0]  MARKER_RESET = 8'd126;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_PARITY  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MARKER = 2'd1,
    ST_PARITY_ERR = 2'd2
  } status_t;

  // Work handed from the front to the back.
  typedef enum logic [2:0] {
    OP_HEADER   = 3'd0,  // header of a frame with payload: latch, no result
    OP_HDR_END  = 3'd1,  // header of an empty frame: latch and close
    OP_PAYLOAD  = 3'd2,
    OP_PARITY   = 3'd3,
    OP_BAD_MARK = 3'd4
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic [7:0] data;
  } qentry_t;

endpackage

`default_nettype wire

// ===== design/xpfp_chan_if.sv =====
// Handshake channels: received bytes in, parser results out.
`default_nettype none

interface xpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface xpfp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [3:0] sequence_res;
  logic [3:0] msg_type;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output sequence_res,
                  output msg_type, output status, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input sequence_res,
                  input msg_type, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== design/xpfp_front.sv =====
// Front end: marker register, frame phase tracking and byte classification.
`default_nettype none

module xpfp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  xpfp_in_if.sink          stream,
  input  logic             q_full,
  output logic             push,
  output xpfp_pkg::qentry_t push_entry
);
  import xpfp_pkg::*;

  logic [7:0] marker;
  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       accept;
  logic       emit;
  op_code_t   op;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;
  assign push         = accept && emit;
  assign push_entry   = '{code: op, data: stream.in_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (cfg_wr_en) begin
      marker <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_comb begin
    phase_next      = PH_IDLE;
    bytes_left_next = bytes_left;
    emit            = 1'b0;
    op              = OP_BAD_MARK;
    case (phase)
      PH_LENGTH: begin
        bytes_left_next = stream.in_byte;
        phase_next      = PH_HEADER;
      end
      PH_HEADER: begin
        emit = 1'b1;
        if (bytes_left == '0) begin
          op         = OP_HDR_END;
          phase_next = PH_IDLE;
        end else begin
          op         = OP_HEADER;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit            = 1'b1;
        op              = OP_PAYLOAD;
        bytes_left_next = bytes_left - 8'd1;
        phase_next      = (bytes_left == 8'd1) ? PH_PARITY : PH_PAYLOAD;
      end
      PH_PARITY: begin
        emit       = 1'b1;
        op         = OP_PARITY;
        phase_next = PH_IDLE;
      end
      default: begin
        // idle, and any unused phase code behaves as idle
        if (stream.in_byte == marker) begin
          phase_next = PH_LENGTH;
        end else begin
          emit = 1'b1;
          op   = OP_BAD_MARK;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/xpfp_queue.sv =====
// Short word queue between the front and back ends.
`default_nettype none

`include "xor_parity_frame_parser_macros.svh"

module xpfp_queue #(
  parameter int unsigned DEPTH = xpfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xpfp_pkg::qentry_t push_entry,
  input  logic              pop,
  output xpfp_pkg::qentry_t head,
  output logic              full,
  output logic              empty
);
  import xpfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qentry_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `XPFP_ASSERT_IMPL(a_no_overflow, push, !full)
  `XPFP_ASSERT_IMPL(a_no_underflow, pop, !empty)
  `XPFP_ASSERT_IMPL(a_count_range, 1'b1, count <= CNT_W'(DEPTH))
  `XPFP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== design/xpfp_back.sv =====
// Back end: header latch, running parity and the result register.
`default_nettype none

module xpfp_back (
  input  logic              clk,
  input  logic              rst,
  input  xpfp_pkg::qentry_t head,
  input  logic              empty,
  output logic              pop,
  xpfp_out_if.source        results
);
  import xpfp_pkg::*;

  logic [7:0] parity, parity_next;
  logic [3:0] held_seq, held_seq_next;
  logic [3:0] held_type, held_type_next;

  logic       res_valid, res_valid_next;
  logic       res_kind, res_kind_next;
  logic [7:0] res_data, res_data_next;
  logic [3:0] res_seq, res_seq_next;
  logic [3:0] res_type, res_type_next;
  status_t    res_status, res_status_next;

  assign pop = !empty && (!res_valid || results.ready);

  assign results.valid        = res_valid;
  assign results.kind         = res_kind;
  assign results.data_byte    = res_data;
  assign results.sequence_res = res_seq;
  assign results.msg_type     = res_type;
  assign results.status       = res_status;
  assign results.last         = (res_kind == KIND_STATUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      parity    <= '0;
      held_seq  <= '0;
      held_type <= '0;
    end else begin
      res_valid <= res_valid_next;
      parity    <= parity_next;
      held_seq  <= held_seq_next;
      held_type <= held_type_next;
    end
  end

  always_ff @(posedge clk) begin
    res_kind   <= res_kind_next;
    res_data   <= res_data_next;
    res_seq    <= res_seq_next;
    res_type   <= res_type_next;
    res_status <= res_status_next;
  end

  always_comb begin
    parity_next     = parity;
    held_seq_next   = held_seq;
    held_type_next  = held_type;
    res_valid_next  = res_valid && !results.ready;
    res_kind_next   = res_kind;
    res_data_next   = res_data;
    res_seq_next    = res_seq;
    res_type_next   = res_type;
    res_status_next = res_status;
    if (pop) begin
      case (head.code)
        OP_HEADER: begin
          held_seq_next  = head.data[7:4] & NIBBLE_MASK;
          held_type_next = head.data[3:0] & NIBBLE_MASK;
          parity_next    = '0;
          res_valid_next = 1'b0;
        end
        OP_HDR_END: begin
          held_seq_next   = head.data[7:4] & NIBBLE_MASK;
          held_type_next  = head.data[3:0] & NIBBLE_MASK;
          parity_next     = '0;
          res_valid_next  = 1'b1;
          res_kind_next   = KIND_STATUS;
          res_data_next   = '0;
          res_seq_next    = head.data[7:4];
          res_type_next   = head.data[3:0];
          res_status_next = ST_OK;
        end
        OP_PAYLOAD: begin
          parity_next     = parity ^ head.data;
          res_valid_next  = 1'b1;
          res_kind_next   = KIND_PAYLOAD;
          res_data_next   = head.data;
          res_seq_next    = held_seq;
          res_type_next   = held_type;
          res_status_next = ST_OK;
        end
        OP_PARITY: begin
          res_valid_next  = 1'b1;
          res_kind_next   = KIND_STATUS;
          res_data_next   = '0;
          res_seq_next    = held_seq;
          res_type_next   = held_type;
          res_status_next = (head.data == parity) ? ST_OK : ST_PARITY_ERR;
        end
        default: begin
          // bad marker: held nibbles stay, result carries zeros
          res_valid_next  = 1'b1;
          res_kind_next   = KIND_STATUS;
          res_data_next   = '0;
          res_seq_next    = '0;
          res_type_next   = '0;
          res_status_next = ST_BAD_MARKER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/xor_parity_frame_parser.sv =====
// Top level of the length-prefixed frame parser with XOR parity check.
//
//   channel   dir   word                          accepted when
//   stream    in    in_byte                       valid & ready
//   results   out   kind, data_byte, sequence_res, valid & ready
//                   msg_type, status, last
//   cfg       in    cfg_wr_data (marker byte)     cfg_wr_en
//
// One byte is taken every cycle while the queue is not full; a result passes the queue, then the result register.
// The front classifies each byte and the back owns parity and the result
// register; a QDEPTH-word queue between them absorbs result back-pressure.
// stream.ready drops only when that queue is full.
// Synchronous reset clears phase, queue and result valid, marker to 126.
`default_nettype none

module xor_parity_frame_parser #(
  parameter int unsigned QDEPTH = xpfp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  xpfp_in_if.sink    stream,
  xpfp_out_if.source results
);
  import xpfp_pkg::*;

  logic    push, pop, q_full, q_empty;
  qentry_t push_entry, head;

  xpfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .stream     (stream),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  xpfp_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  xpfp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .results(results)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the frame parser: directed table, random frames, marker changes.
`timescale 1ns / 100ps

module tb_top;
  import xpfp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] sequence_res;
    logic [3:0] msg_type;
    status_t    status;
    logic       last;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       typed;
    frame_res_t res;
  } stim_row_t;

  localparam frame_res_t NO_RES = '0;
  localparam frame_res_t BAD_MARK_RES = '{KIND_STATUS, 8'h00, 4'h0, 4'h0, ST_BAD_MARKER, 1'b1};

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  xpfp_in_if  stream_if ();
  xpfp_out_if res_if ();

  xor_parity_frame_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stream      (stream_if),
    .results     (res_if)
  );

  // Directed stimulus; a typed result replaces the predicted one for that word.
  stim_row_t dir_rows [0:22] = '{
    '{8'h00, 1'b1, BAD_MARK_RES},
    '{8'hFF, 1'b1, BAD_MARK_RES},
    '{8'h7D, 1'b1, BAD_MARK_RES},
    '{8'h7F, 1'b1, BAD_MARK_RES},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_STATUS, 8'h00, 4'hF, 4'hF, ST_OK, 1'b1}},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 4'h0, 4'h0, ST_OK, 1'b0}},
    '{8'hFF, 1'b1, '{KIND_STATUS, 8'h00, 4'h0, 4'h0, ST_OK, 1'b1}},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'hA5, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h3C, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_STATUS, 8'h00, 4'hA, 4'h5, ST_PARITY_ERR, 1'b1}},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'h81, 1'b0, NO_RES},
    '{8'h81, 1'b0, NO_RES}
  };

  // Parser state as predicted from the accepted words
  phase_t     ph;
  logic [7:0] left_cnt;
  logic [7:0] xor_acc;
  logic [3:0] hdr_seq;
  logic [3:0] hdr_type;
  logic [7:0] marker_val;

  frame_res_t pending_res [$];
  int         mismatches;
  int         words_sent;
  bit         src_burst;
  bit         sink_burst;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit parse_byte(input logic [7:0] b, output frame_res_t r);
    r = NO_RES;
    case (ph)
      PH_LENGTH: begin
        left_cnt = b;
        ph = PH_HEADER;
        return 1'b0;
      end
      PH_HEADER: begin
        hdr_seq = b[7:4];
        hdr_type = b[3:0] & NIBBLE_MASK;
        xor_acc = 8'h00;
        if (left_cnt == 8'd0) begin
          ph = PH_IDLE;
          r = '{KIND_STATUS, 8'h00, hdr_seq, hdr_type, ST_OK, 1'b1};
          return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        xor_acc = xor_acc ^ b;
        left_cnt = left_cnt - 8'd1;
        if (left_cnt == 8'd0) ph = PH_PARITY;
        r = '{KIND_PAYLOAD, b, hdr_seq, hdr_type, ST_OK, 1'b0};
        return 1'b1;
      end
      PH_PARITY: begin
        ph = PH_IDLE;
        r = '{KIND_STATUS, 8'h00, hdr_seq, hdr_type,
              (b == xor_acc) ? ST_OK : ST_PARITY_ERR, 1'b1};
        return 1'b1;
      end
      default: begin
        ph = PH_IDLE;
        if (b == marker_val) begin
          ph = PH_LENGTH;
          return 1'b0;
        end
        r = BAD_MARK_RES;
        return 1'b1;
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Entered and left at a falling edge; valid stays high on exit
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_res_t typed_res = NO_RES);
    int gap;
    frame_res_t r;
    gap = (!src_burst && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      stream_if.valid = 1'b0;
      stream_if.in_byte = 8'($urandom);
      @(negedge clk);
    end
    stream_if.valid = 1'b1;
    stream_if.in_byte = b;
    do @(posedge clk); while (!stream_if.ready);
    @(negedge clk);
    words_sent++;
    if (parse_byte(b, r)) pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic send_frame(input bit whole);
    int r;
    int len;
    int upto;
    logic [7:0] hdr;
    logic [7:0] pb;
    logic [7:0] acc;
    r = $urandom_range(0, 99);
    if (r < 3) len = 255;
    else if (r < 13) len = 0;
    else if (r < 20) len = $urandom_range(9, 40);
    else len = $urandom_range(1, 8);
    hdr = 8'($urandom);
    acc = 8'h00;
    upto = whole ? len : $urandom_range(0, len);
    send_byte(marker_val);
    send_byte(8'(len));
    send_byte(hdr);
    for (int i = 0; i < upto; i++) begin
      pb = 8'($urandom);
      acc = acc ^ pb;
      send_byte(pb);
    end
    if (whole && len != 0) begin
      if ($urandom_range(0, 7) != 0) send_byte(acc);
      else send_byte(acc ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    int r;
    start = words_sent;
    while (words_sent - start < target) begin
      if ($urandom_range(0, 19) == 0) src_burst = !src_burst;
      r = $urandom_range(0, 99);
      if (r < 80) send_frame(1'b1);
      else if (r < 92) send_byte(8'($urandom));
      else send_frame(1'b0);
    end
    // drain any broken frame back to idle
    while (ph != PH_IDLE) send_byte(8'($urandom));
  endtask

  // Only while idle: no word in flight and every result delivered
  task automatic set_marker(input logic [7:0] value);
    stream_if.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    marker_val = value;
  endtask

  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else if (!sink_burst && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        stall = pick_gap() - 1;
      end else begin
        res_if.ready = 1'b1;
      end
      if ($urandom_range(0, 199) == 0) sink_burst = !sink_burst;
    end
  end

  always @(posedge clk) begin
    frame_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        note_mismatch("unexpected word", res_if.kind, 0);
      end else begin
        want = pending_res.pop_front();
        if (res_if.kind !== want.kind)
          note_mismatch("kind", res_if.kind, want.kind);
        if (res_if.data_byte !== want.data_byte)
          note_mismatch("data_byte", res_if.data_byte, want.data_byte);
        if (res_if.sequence_res !== want.sequence_res)
          note_mismatch("sequence_res", res_if.sequence_res, want.sequence_res);
        if (res_if.msg_type !== want.msg_type)
          note_mismatch("msg_type", res_if.msg_type, want.msg_type);
        if (res_if.status !== want.status)
          note_mismatch("status", res_if.status, want.status);
        if (res_if.last !== want.last)
          note_mismatch("last", res_if.last, want.last);
      end
    end
  end

  initial begin
    int waited;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    stream_if.valid = 1'b0;
    stream_if.in_byte = 8'h00;
    ph = PH_IDLE;
    left_cnt = 8'h00;
    xor_acc = 8'h00;
    hdr_seq = 4'h0;
    hdr_type = 4'h0;
    marker_val = MARKER_RESET;
    mismatches = 0;
    words_sent = 0;
    src_burst = 1'b0;
    sink_burst = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].in_byte, dir_rows[i].typed, dir_rows[i].res);

    set_marker(8'h00);
    run_random(125);
    set_marker(8'hFF);
    run_random(125);
    set_marker(8'($urandom_range(1, 254)));
    run_random(125);
    set_marker(MARKER_RESET);
    run_random(125);

    stream_if.valid = 1'b0;
    waited = 0;
    while (pending_res.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (pending_res.size() != 0) note_mismatch("words never delivered", pending_res.size(), 0);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
